// ----- src/xetc_pkg.sv -----
package xetc_pkg;

    // capture buffer depth and derived widths
    localparam int TEXT_MAX = 32;
    localparam int LEN_W    = $clog2(TEXT_MAX + 1);
    localparam int ADDR_W   = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;

    localparam logic [3:0] FIELDS_RESET = 4'd5;

    // character codes
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // bracket count that marks a simple element line
    localparam logic [1:0] CNT_MATCH = 2'd2;
    localparam logic [1:0] CNT_SAT   = 2'd3;

    // request kinds carried in tuser
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // capture phase codes
    localparam logic [1:0] PH_BEFORE  = 2'd0;
    localparam logic [1:0] PH_CAPTURE = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_TEXT  = 5'b00100,
        S_SEP1  = 5'b01000,
        S_SEP2  = 5'b10000
    } state_t;

endpackage

// ----- src/xml_element_text_to_csv_core.sv -----
// a data byte is taken and gives no output
// a matching line end sends each stored text byte by a buffer read, then an
// output load, then an end-of-text check and one or two separator loads
// s_axis_tready is low from a matching line end until the last separator is loaded
// rst_n is asynchronous and active low: clears line state, row position,
// sequencer and output valid; fields_per_row returns to 5
module xml_element_text_to_csv_core (
    input  logic       clk,
    input  logic       rst_n,
    // configuration: fields_per_row
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    // input requests
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] kind
    // output requests
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // last byte of the run
);

    localparam int LEN_W  = xetc_pkg::LEN_W;
    localparam int ADDR_W = xetc_pkg::ADDR_W;

    // sequencer and line state
    xetc_pkg::state_t state_reg, state_next;
    logic [3:0]       fields_reg;
    logic [1:0]       open_reg, open_next;
    logic [1:0]       close_reg, close_next;
    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [3:0]       fpos_reg, fpos_next;

    // drain control
    logic [LEN_W-1:0] drain_len_reg, drain_len_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             comma_reg, comma_next;

    // capture buffer, no reset
    logic [7:0] text_store_reg [xetc_pkg::TEXT_MAX];
    logic [7:0] rd_data_reg;
    logic       wr_en;
    logic [7:0] wr_data;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       load;
    logic [7:0] load_byte;
    logic       load_last;

    logic accept;
    logic line_end;
    logic match;
    logic slot_free;
    logic idx_lt_len;
    logic row_continues;

    assign s_axis_tready = (state_reg == xetc_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign line_end      = (s_axis_tuser == xetc_pkg::KIND_EOS)
                        || (s_axis_tdata == xetc_pkg::CH_NEWLINE);
    assign match         = (open_reg == xetc_pkg::CNT_MATCH)
                        && (close_reg == xetc_pkg::CNT_MATCH);
    assign slot_free     = !out_valid_reg || m_axis_tready;

    // the one compare used by the drain loop
    assign idx_lt_len    = (idx_reg < drain_len_reg);

    // another value fits in this row; a width of zero acts as one
    assign row_continues = ({1'b0, fpos_reg} + 5'd1) < {1'b0, fields_reg};

    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        close_next     = close_reg;
        phase_next     = phase_reg;
        len_next       = len_reg;
        fpos_next      = fpos_reg;
        drain_len_next = drain_len_reg;
        idx_next       = idx_reg;
        comma_next     = comma_reg;
        wr_en          = 1'b0;
        wr_data        = (s_axis_tdata == xetc_pkg::CH_COMMA) ? xetc_pkg::CH_SPACE
                                                              : s_axis_tdata;
        load           = 1'b0;
        load_byte      = xetc_pkg::CH_NEWLINE;
        load_last      = 1'b0;

        unique case (state_reg)
            xetc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (line_end)
                    begin
                        // close the line and start the drain if it matched
                        if (match)
                        begin
                            drain_len_next = len_reg;
                            idx_next       = '0;
                            comma_next     = row_continues;
                            fpos_next      = row_continues ? fpos_reg + 4'd1 : 4'd0;
                            state_next     = xetc_pkg::S_FETCH;
                        end
                        if (s_axis_tuser == xetc_pkg::KIND_EOS)
                        begin
                            fpos_next = 4'd0;
                        end
                        open_next  = 2'd0;
                        close_next = 2'd0;
                        phase_next = xetc_pkg::PH_BEFORE;
                        len_next   = '0;
                    end
                    else if (s_axis_tdata == xetc_pkg::CH_LT)
                    begin
                        if (open_reg != xetc_pkg::CNT_SAT)
                        begin
                            open_next = open_reg + 2'd1;
                        end
                        if (phase_reg == xetc_pkg::PH_CAPTURE)
                        begin
                            phase_next = xetc_pkg::PH_DONE;
                        end
                    end
                    else
                    begin
                        // store before the phase moves, so a later '>' is text
                        if (phase_reg == xetc_pkg::PH_CAPTURE
                            && len_reg < LEN_W'(xetc_pkg::TEXT_MAX))
                        begin
                            wr_en    = 1'b1;
                            len_next = len_reg + LEN_W'(1);
                        end
                        if (s_axis_tdata == xetc_pkg::CH_GT)
                        begin
                            if (close_reg != xetc_pkg::CNT_SAT)
                            begin
                                close_next = close_reg + 2'd1;
                            end
                            if (phase_reg == xetc_pkg::PH_BEFORE)
                            begin
                                phase_next = xetc_pkg::PH_CAPTURE;
                            end
                        end
                    end
                end
            end
            xetc_pkg::S_FETCH:
            begin
                // buffer read issued at idx_reg, data ready next cycle
                state_next = idx_lt_len ? xetc_pkg::S_TEXT : xetc_pkg::S_SEP1;
            end
            xetc_pkg::S_TEXT:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    load_byte  = rd_data_reg;
                    idx_next   = idx_reg + LEN_W'(1);
                    state_next = xetc_pkg::S_FETCH;
                end
            end
            xetc_pkg::S_SEP1:
            begin
                if (slot_free)
                begin
                    load = 1'b1;
                    if (comma_reg)
                    begin
                        load_byte  = xetc_pkg::CH_COMMA;
                        state_next = xetc_pkg::S_SEP2;
                    end
                    else
                    begin
                        load_byte  = xetc_pkg::CH_NEWLINE;
                        load_last  = 1'b1;
                        state_next = xetc_pkg::S_IDLE;
                    end
                end
            end
            xetc_pkg::S_SEP2:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    load_byte  = xetc_pkg::CH_SPACE;
                    load_last  = 1'b1;
                    state_next = xetc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = xetc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xetc_pkg::S_IDLE;
            fields_reg    <= xetc_pkg::FIELDS_RESET;
            open_reg      <= 2'd0;
            close_reg     <= 2'd0;
            phase_reg     <= xetc_pkg::PH_BEFORE;
            len_reg       <= '0;
            fpos_reg      <= 4'd0;
            drain_len_reg <= '0;
            idx_reg       <= '0;
            comma_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            close_reg     <= close_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            fpos_reg      <= fpos_next;
            drain_len_reg <= drain_len_next;
            idx_reg       <= idx_next;
            comma_reg     <= comma_next;
            if (cfg_wr_en)
            begin
                fields_reg <= cfg_wr_data;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= load_byte;
            out_last_reg <= load_last;
        end
    end

    // capture buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            text_store_reg[len_reg[ADDR_W-1:0]] <= wr_data;
        end
        rd_data_reg <= text_store_reg[idx_reg[ADDR_W-1:0]];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    // drain index never passes the captured length
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != xetc_pkg::S_IDLE) |-> (idx_reg <= drain_len_reg))
        else $error("drain index past captured length");

    // captured length stays within the buffer
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(xetc_pkg::TEXT_MAX))
        else $error("capture length overflow");

    // a run always ends on a separator byte
    a_last_sep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg)
            |-> (out_byte_reg == xetc_pkg::CH_NEWLINE
                 || out_byte_reg == xetc_pkg::CH_SPACE))
        else $error("run ended on a text byte");

    // the space of a comma separator follows the comma load
    a_sep2_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xetc_pkg::S_SEP2) |-> comma_reg)
        else $error("second separator without comma");

endmodule

// ----- bench/xml_element_text_to_csv_core_test.sv -----
`timescale 1ns / 100ps

module xml_element_text_to_csv_core_test;

    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;

    // names taken over from the shared package
    localparam int         TEXT_MAX     = xetc_pkg::TEXT_MAX;
    localparam int         LEN_W        = xetc_pkg::LEN_W;
    localparam logic [3:0] FIELDS_RESET = xetc_pkg::FIELDS_RESET;
    localparam logic [7:0] CH_LT        = xetc_pkg::CH_LT;
    localparam logic [7:0] CH_GT        = xetc_pkg::CH_GT;
    localparam logic [7:0] CH_COMMA     = xetc_pkg::CH_COMMA;
    localparam logic [7:0] CH_SPACE     = xetc_pkg::CH_SPACE;
    localparam logic [7:0] CH_NEWLINE   = xetc_pkg::CH_NEWLINE;
    localparam logic [1:0] CNT_MATCH    = xetc_pkg::CNT_MATCH;
    localparam logic [1:0] CNT_SAT      = xetc_pkg::CNT_SAT;
    localparam logic       KIND_DATA    = xetc_pkg::KIND_DATA;
    localparam logic       KIND_EOS     = xetc_pkg::KIND_EOS;
    localparam logic [1:0] PH_BEFORE    = xetc_pkg::PH_BEFORE;
    localparam logic [1:0] PH_CAPTURE   = xetc_pkg::PH_CAPTURE;
    localparam logic [1:0] PH_DONE      = xetc_pkg::PH_DONE;

    // one byte of csv output as the block should send it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } csv_char_t;

    // one row of the directed script; e holds up to four typed output bytes,
    // the first one in the lowest bits
    typedef struct packed {
        logic        kind;
        logic [7:0]  b;
        logic        typed;
        logic [2:0]  n;
        logic [31:0] e;
    } script_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [3:0] cfg_wr_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    xml_element_text_to_csv_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // line tracker mirror
    logic [1:0]       lt_count;
    logic [1:0]       gt_count;
    logic [1:0]       cap_phase;
    logic [7:0]       text_buf [TEXT_MAX];
    logic [LEN_W-1:0] text_len;
    logic [3:0]       row_pos;
    logic [3:0]       row_width;

    csv_char_t   csv_expected [$];
    csv_char_t   line_out [$];
    script_row_t script [$];

    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;

    int items_sent;
    int bytes_checked;
    int values_emitted;
    int widths_used;
    int long_holds;
    int mismatches;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // line end: a line with exactly two of each bracket gives its text
    // and then a separator, or a newline once the row is full
    task automatic close_line_predict();
        csv_char_t c;
        if (lt_count == CNT_MATCH && gt_count == CNT_MATCH)
        begin
            for (int i = 0; i < int'(text_len) && i < TEXT_MAX; i++)
            begin
                c.data = text_buf[i];
                c.last = 1'b0;
                line_out.push_back(c);
            end
            c.last = 1'b0;
            if (int'(row_pos) + 1 < int'(row_width))
            begin
                c.data = CH_COMMA;
                line_out.push_back(c);
                c.data = CH_SPACE;
                line_out.push_back(c);
                row_pos = row_pos + 4'd1;
            end
            else
            begin
                c.data = CH_NEWLINE;
                line_out.push_back(c);
                row_pos = '0;
            end
            c = line_out.pop_back();
            c.last = 1'b1;
            line_out.push_back(c);
            values_emitted++;
        end
        lt_count  = '0;
        gt_count  = '0;
        cap_phase = PH_BEFORE;
        text_len  = '0;
    endtask

    // works out the output bytes of one accepted request into line_out
    task automatic csv_predict(input logic kind, input logic [7:0] b);
        line_out.delete();
        if (kind == KIND_EOS)
        begin
            close_line_predict();
            row_pos = '0;
        end
        else if (b == CH_NEWLINE)
            close_line_predict();
        else if (b == CH_LT)
        begin
            if (lt_count != CNT_SAT)
                lt_count = lt_count + 2'd1;
            if (cap_phase == PH_CAPTURE)
                cap_phase = PH_DONE;
        end
        else
        begin
            if (cap_phase == PH_CAPTURE && int'(text_len) < TEXT_MAX)
            begin
                text_buf[text_len] = (b == CH_COMMA) ? CH_SPACE : b;
                text_len = text_len + LEN_W'(1);
            end
            if (b == CH_GT)
            begin
                if (gt_count != CNT_SAT)
                    gt_count = gt_count + 2'd1;
                if (cap_phase == PH_BEFORE)
                    cap_phase = PH_CAPTURE;
            end
        end
    endtask

    // offer one request, wait for it to be taken, then queue what it gives;
    // a typed row queues its own bytes in place of the predicted ones
    task automatic send(input logic kind, input logic [7:0] b, input bit typed = 1'b0,
                        input logic [2:0] n = '0, input logic [31:0] e = '0);
        int        gap;
        csv_char_t c;
        @(negedge clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
        csv_predict(kind, b);
        if (typed)
        begin
            for (int k = 0; k < int'(n); k++)
            begin
                c.data = e[8 * k +: 8];
                c.last = (k == int'(n) - 1);
                csv_expected.push_back(c);
            end
        end
        else
        begin
            foreach (line_out[k])
                csv_expected.push_back(line_out[k]);
        end
    endtask

    // sender stops and waits for every queued byte, then lets the block settle
    task automatic drain_out(input int extra);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (csv_expected.size() != 0) @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_text_byte();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 31);
        if (r < 4)
            b = CH_COMMA;
        else if (r == 4)
            b = 8'h0D;
        else if (r == 5)
            b = CH_GT;  // spoils the match
        else if (r < 9)
            b = 8'($urandom_range(128, 255));
        else if (r == 9)
            b = 8'h00;
        else
            b = 8'($urandom_range(32, 126));
        if (b == CH_LT)
            b = CH_SPACE;
        return b;
    endfunction

    function automatic logic [7:0] pick_tag_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_LT || b == CH_GT || b == CH_NEWLINE)
            b = 8'h61;
        return b;
    endfunction

    task automatic send_random_line();
        int         sel;
        int         len;
        logic [7:0] b;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            // element line: <tag>text</tag> with random content
            send(KIND_DATA, CH_LT);
            len = $urandom_range(0, 3);
            repeat (len) send(KIND_DATA, pick_tag_byte());
            send(KIND_DATA, CH_GT);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 8);
            repeat (len) send(KIND_DATA, pick_text_byte());
            send(KIND_DATA, CH_LT);
            send(KIND_DATA, 8'h2F);
            len = $urandom_range(0, 3);
            repeat (len) send(KIND_DATA, pick_tag_byte());
            send(KIND_DATA, CH_GT);
            if ($urandom_range(0, 7) == 0)
                send(KIND_DATA, 8'h0D);
            if ($urandom_range(0, 7) == 0)
                send(KIND_EOS, 8'($urandom_range(0, 255)));
            else
                send(KIND_DATA, CH_NEWLINE);
        end
        else if (sel < 8)
        begin
            // broken line: brackets in random number and order
            len = $urandom_range(1, 10);
            repeat (len)
            begin
                case ($urandom_range(0, 2))
                    0: b = CH_LT;
                    1: b = CH_GT;
                    default: b = pick_tag_byte();
                endcase
                send(KIND_DATA, b);
            end
            if ($urandom_range(0, 5) == 0)
                send(KIND_EOS, 8'($urandom_range(0, 255)));
            else
                send(KIND_DATA, CH_NEWLINE);
        end
        else if (sel == 8)
        begin
            // plain noise
            len = $urandom_range(1, 12);
            repeat (len) send(KIND_DATA, 8'($urandom_range(0, 255)));
        end
        else
            send(KIND_EOS, 8'($urandom_range(0, 255)));
    endtask

    // block is idle here: write the row width, then run random lines
    task automatic run_phase(input logic [3:0] width, input int n_items, input bit long_hold,
                             input bit mid_pause, input bit idle);
        int start;
        bit paused;
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= width;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        row_width = width;
        widths_used++;
        tx_idle_on = idle;
        rx_idle_on = idle;
        if (long_hold)
            hold_req = 1'b1;
        start  = items_sent;
        paused = 1'b0;
        while (items_sent - start < n_items)
        begin
            if (mid_pause && !paused && items_sent - start >= n_items / 2)
            begin
                drain_out(0);
                paused = 1'b1;
            end
            send_random_line();
        end
        drain_out(SETTLE_CYCLES);
    endtask

    function automatic void row(input logic kind, input logic [7:0] b, input bit typed = 1'b0,
                                input logic [2:0] n = '0, input logic [31:0] e = '0);
        script_row_t r;
        r.kind  = kind;
        r.b     = b;
        r.typed = typed;
        r.n     = n;
        r.e     = e;
        script.push_back(r);
    endfunction

    // receiver: random stalls, plus one long hold when asked
    initial
    begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold = LONG_HOLD - 1;
                long_holds++;
                m_axis_tready <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // output checker
    initial
    begin
        csv_char_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                bytes_checked++;
                if (csv_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected output byte %02h last %0b",
                                 $realtime, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = csv_expected.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: out_byte exp %02h got %02h, last exp %0b got %0b",
                                     $realtime, want.data, m_axis_tdata, want.last,
                                     m_axis_tlast);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_DATA;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_req      = 1'b0;
        lt_count      = '0;
        gt_count      = '0;
        cap_phase     = PH_BEFORE;
        text_len      = '0;
        row_pos       = '0;
        row_width     = FIELDS_RESET;
        foreach (text_buf[i])
            text_buf[i] = '0;

        // directed script at the reset row width of five; typed bytes are
        // listed last byte first
        // short element line: text then comma and space
        row(KIND_DATA, CH_LT); row(KIND_DATA, CH_GT); row(KIND_DATA, 8'h78);
        row(KIND_DATA, CH_LT); row(KIND_DATA, CH_GT);
        row(KIND_DATA, CH_NEWLINE, 1'b1, 3'd3, {8'h00, CH_SPACE, CH_COMMA, 8'h78});
        // comma stored as space, carriage return kept, end of stream closes
        // the line; its data byte is a newline that must be ignored
        row(KIND_DATA, CH_LT); row(KIND_DATA, CH_GT); row(KIND_DATA, CH_COMMA);
        row(KIND_DATA, 8'h0D); row(KIND_DATA, CH_LT); row(KIND_DATA, CH_GT);
        row(KIND_EOS, CH_NEWLINE, 1'b1, 3'd4, {CH_SPACE, CH_COMMA, 8'h0D, CH_SPACE});
        // end of stream on an empty line gives nothing
        row(KIND_EOS, 8'hFF, 1'b1, 3'd0, '0);
        // byte extremes as text, fresh row after end of stream
        row(KIND_DATA, CH_LT); row(KIND_DATA, CH_GT); row(KIND_DATA, 8'h00);
        row(KIND_DATA, 8'hFF); row(KIND_DATA, CH_LT); row(KIND_DATA, CH_GT);
        row(KIND_DATA, CH_NEWLINE, 1'b1, 3'd4, {CH_SPACE, CH_COMMA, 8'hFF, 8'h00});
        // empty text: separator only
        row(KIND_DATA, CH_LT); row(KIND_DATA, CH_GT); row(KIND_DATA, CH_LT);
        row(KIND_DATA, CH_GT);
        row(KIND_DATA, CH_NEWLINE, 1'b1, 3'd2, {16'h0000, CH_SPACE, CH_COMMA});

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send(script[i].kind, script[i].b, script[i].typed, script[i].n, script[i].e);
        drain_out(SETTLE_CYCLES);

        // phases end mid-row at times, so a new width can land on a partly
        // filled row
        run_phase(4'd1, 60, 1'b0, 1'b0, 1'b1);
        run_phase(4'd15, 110, 1'b1, 1'b0, 1'b1);
        run_phase(4'd0, 50, 1'b0, 1'b0, 1'b1);
        run_phase(4'd3, 90, 1'b0, 1'b1, 1'b1);
        run_phase(4'($urandom_range(1, 15)), 90, 1'b0, 1'b0, 1'b1);
        run_phase(4'd2, 70, 1'b0, 1'b0, 1'b0);

        $display("%0d requests over %0d row widths, %0d values emitted, %0d output bytes checked",
                 items_sent, widths_used, values_emitted, bytes_checked);
        $display("%0d long output holds, %0d mismatches", long_holds, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
